/* rtl/core/assert_macros.svh */
// Assertion macros shared by the rail fence transposer RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef NO_ASSERTIONS
`define RFT_ASSERT(lbl, clk, rstn, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (prop)) \
    else $error("rft assertion failed");
`define RFT_ASSERT_NEVER(lbl, clk, rstn, expr) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) !(expr)) \
    else $error("rft forbidden condition seen");
`else
`define RFT_ASSERT(lbl, clk, rstn, prop)
`define RFT_ASSERT_NEVER(lbl, clk, rstn, expr)
`endif
`endif

/* rtl/core/rft_pkg.sv */
// Shared types and constants of the rail fence transposer.
package rft_pkg;

  localparam int unsigned MAX_LEN_DEF = 64;
  localparam int unsigned BYTE_W      = 8;
  localparam int unsigned RAIL_W      = 7;
  localparam int unsigned CFG_ADDR_W  = 8;
  localparam int unsigned CFG_DATA_W  = 8;

  localparam logic [CFG_ADDR_W-1:0] REG_RAIL_COUNT  = 8'd0;
  localparam logic [CFG_ADDR_W-1:0] REG_DECRYPT     = 8'd1;
  localparam logic [RAIL_W-1:0]     RAIL_COUNT_RST  = 7'd3;

  typedef enum logic [1:0] {
    ST_LOAD,
    ST_GATHER,
    ST_SCATTER,
    ST_DRAIN
  } rft_state_e;

  typedef struct packed {
    logic [BYTE_W-1:0] out_byte;
    logic              out_final;
    logic              overflow;
  } rft_out_item_t;

  typedef struct packed {
    logic start;
    logic advance;
  } rft_gen_ctrl_t;

endpackage

/* rtl/core/rft_ifs.sv */
// Channel interfaces of the rail fence transposer: input, output and config.
interface rft_in_if;
  import rft_pkg::*;
  logic              valid;
  logic              ready;
  logic [BYTE_W-1:0] data_byte;
  logic              is_final;
  modport source (output valid, output data_byte, output is_final, input ready);
  modport sink   (input valid, input data_byte, input is_final, output ready);
endinterface

interface rft_out_if;
  import rft_pkg::*;
  logic              valid;
  logic              ready;
  logic [BYTE_W-1:0] out_byte;
  logic              out_final;
  logic              overflow;
  modport source (output valid, output out_byte, output out_final, output overflow,
                  input ready);
  modport sink   (input valid, input out_byte, input out_final, input overflow,
                  output ready);
endinterface

interface rft_cfg_if;
  import rft_pkg::*;
  logic                  valid;
  logic                  ready;
  logic [CFG_ADDR_W-1:0] addr;
  logic [CFG_DATA_W-1:0] data;
  modport source (output valid, output addr, output data, input ready);
  modport sink   (input valid, input addr, input data, output ready);
endinterface

/* rtl/core/rft_ram.sv */
// Generic single-write, single-read synchronous RAM with registered read.
module rft_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 64
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_o <= mem_q[raddr_i];
    end
  end

endmodule

/* rtl/core/rft_order_gen.sv */
// Rail-order index generator: walks the zigzag rail by rail, one position per step.
module rft_order_gen #(
  parameter int unsigned MAX_LEN = rft_pkg::MAX_LEN_DEF
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  rft_pkg::rft_gen_ctrl_t         ctrl_i,
  input  logic [$clog2(MAX_LEN+1)-1:0]   len_i,
  input  logic [rft_pkg::RAIL_W-1:0]     rails_i,
  output logic [$clog2(MAX_LEN)-1:0]     idx_o,
  output logic [$clog2(MAX_LEN)-1:0]     cnt_o,
  output logic                           last_o
);
  import rft_pkg::*;

  localparam int unsigned LEN_W  = $clog2(MAX_LEN + 1);
  localparam int unsigned ADDR_W = $clog2(MAX_LEN);
  localparam int unsigned STEP_W = RAIL_W + 1;
  localparam int unsigned POS_W  = $clog2(MAX_LEN + (2 ** STEP_W));

  logic [RAIL_W-1:0] rail_q, rail_d;
  logic [ADDR_W-1:0] pos_q, pos_d;
  logic [ADDR_W-1:0] cnt_q, cnt_d;
  logic              phase_q, phase_d;

  logic [RAIL_W-1:0] rails_eff;
  logic [RAIL_W-1:0] rails_m1;
  logic [RAIL_W-1:0] rail_nxt;
  logic [STEP_W-1:0] period;
  logic [STEP_W-1:0] two_rail;
  logic [STEP_W-1:0] step;
  logic [POS_W-1:0]  pos_sum;
  logic              outer_rail;
  logic              stay;

  always_comb begin
    rails_eff  = (rails_i == '0) ? RAIL_W'(1) : rails_i;
    rails_m1   = rails_eff - RAIL_W'(1);
    period     = {rails_m1, 1'b0};
    two_rail   = {rail_q, 1'b0};
    outer_rail = (rail_q == '0) || (rail_q == rails_m1);
    // a single rail walks every position in order
    if (rails_m1 == '0) begin
      step = STEP_W'(1);
    end else if (outer_rail) begin
      step = period;
    end else if (phase_q) begin
      step = two_rail;
    end else begin
      step = period - two_rail;
    end
    pos_sum  = POS_W'(pos_q) + POS_W'(step);
    stay     = pos_sum < POS_W'(len_i);
    rail_nxt = rail_q + RAIL_W'(1);
  end

  always_comb begin
    rail_d  = rail_q;
    pos_d   = pos_q;
    cnt_d   = cnt_q;
    phase_d = phase_q;
    if (ctrl_i.start) begin
      rail_d  = '0;
      pos_d   = '0;
      cnt_d   = '0;
      phase_d = 1'b0;
    end else if (ctrl_i.advance) begin
      cnt_d = cnt_q + ADDR_W'(1);
      if (stay) begin
        pos_d   = pos_sum[ADDR_W-1:0];
        phase_d = ~phase_q;
      end else begin
        // next rail starts at its own index
        rail_d  = rail_nxt;
        pos_d   = ADDR_W'(rail_nxt);
        phase_d = 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rail_q  <= '0;
      pos_q   <= '0;
      cnt_q   <= '0;
      phase_q <= 1'b0;
    end else begin
      rail_q  <= rail_d;
      pos_q   <= pos_d;
      cnt_q   <= cnt_d;
      phase_q <= phase_d;
    end
  end

  assign idx_o  = pos_q;
  assign cnt_o  = cnt_q;
  assign last_o = (LEN_W'(cnt_q) + LEN_W'(1)) == len_i;

endmodule

/* rtl/core/rft_out_buf.sv */
// Two-entry output buffer that decouples RAM reads from output backpressure.
module rft_out_buf (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  push_i,
  input  rft_pkg::rft_out_item_t item_i,
  output logic [1:0]            cnt_o,
  output logic                  pop_o,
  rft_out_if.source             out_o
);
  import rft_pkg::*;

  rft_out_item_t ent0_q, ent0_d;
  rft_out_item_t ent1_q, ent1_d;
  logic [1:0]    cnt_q, cnt_d;
  logic          pop;

  assign pop = out_o.valid && out_o.ready;

  always_comb begin
    ent0_d = ent0_q;
    ent1_d = ent1_q;
    cnt_d  = cnt_q + {1'b0, push_i} - {1'b0, pop};
    if (pop) begin
      ent0_d = ent1_q;
      if (push_i) begin
        if (cnt_q == 2'd1) begin
          ent0_d = item_i;
        end else begin
          ent1_d = item_i;
        end
      end
    end else if (push_i) begin
      if (cnt_q == 2'd0) begin
        ent0_d = item_i;
      end else begin
        ent1_d = item_i;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= '0;
    end else begin
      cnt_q <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    ent0_q <= ent0_d;
    ent1_q <= ent1_d;
  end

  assign out_o.valid     = cnt_q != 2'd0;
  assign out_o.out_byte  = ent0_q.out_byte;
  assign out_o.out_final = ent0_q.out_final;
  assign out_o.overflow  = ent0_q.overflow;
  assign cnt_o           = cnt_q;
  assign pop_o           = pop;

endmodule

/* rtl/core/rail_fence_transposer_core.sv */
// Top level of the rail fence transposer: message buffer, sequencer and output.
//
//  channel | dir | payload                          | accepted when
//  --------+-----+----------------------------------+------------------
//  cfg_i   | in  | addr, data                       | valid && ready
//  in_i    | in  | data_byte, is_final              | valid && ready
//  out_o   | out | out_byte, out_final, overflow    | valid && ready
//
//  Loading writes the message bytes into the message RAM; the burst follows.
//  Encrypt: one gather read of the message RAM per result.
//  Decrypt: one scatter write into the result RAM per byte, then one read per result.
//  Input is held off during the burst; output stalls pause the RAM reads.
//  Reset clears all control state; RAM contents are undefined until written.
`include "assert_macros.svh"

module rail_fence_transposer_core #(
  parameter int unsigned MAX_LEN = rft_pkg::MAX_LEN_DEF
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  rft_cfg_if.sink    cfg_i,
  rft_in_if.sink     in_i,
  rft_out_if.source  out_o
);
  import rft_pkg::*;

  localparam int unsigned LEN_W  = $clog2(MAX_LEN + 1);
  localparam int unsigned ADDR_W = $clog2(MAX_LEN);

  rft_state_e        state_q, state_d;
  logic [RAIL_W-1:0] rail_q;
  logic              dec_q;
  logic [LEN_W-1:0]  len_q, len_d;
  logic              ovf_q, ovf_d;
  logic [ADDR_W-1:0] k_q, k_d;
  logic              rd_pend_q;
  logic              rd_from_b_q;
  logic              rd_last_q;
  logic              rd_ovf_q;
  logic              wr_pend_q;
  logic [ADDR_W-1:0] wr_addr_q;

  logic              in_acc;
  logic              room;
  logic              cfg_acc;
  logic              issue;
  logic              issue_last;
  logic              can_issue;
  logic              burst_done;
  logic              we_a;
  logic              re_a;
  logic [ADDR_W-1:0] raddr_a;
  logic [BYTE_W-1:0] rdata_a;
  logic              re_b;
  logic [ADDR_W-1:0] raddr_b;
  logic [BYTE_W-1:0] rdata_b;
  logic              scat;

  rft_gen_ctrl_t     gen_ctrl;
  logic [ADDR_W-1:0] gen_idx;
  logic [ADDR_W-1:0] gen_cnt;
  logic              gen_last;

  logic [1:0]        buf_cnt;
  logic              buf_pop;
  rft_out_item_t     push_item;
  logic [2:0]        occupancy;

  // configuration
  assign cfg_i.ready = 1'b1;
  assign cfg_acc     = cfg_i.valid && cfg_i.ready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rail_q <= RAIL_COUNT_RST;
      dec_q  <= 1'b0;
    end else if (cfg_acc) begin
      if (cfg_i.addr == REG_RAIL_COUNT) begin
        rail_q <= cfg_i.data[RAIL_W-1:0];
      end else if (cfg_i.addr == REG_DECRYPT) begin
        dec_q <= cfg_i.data[0];
      end
    end
  end

  assign in_i.ready = (state_q == ST_LOAD);
  assign in_acc     = in_i.valid && in_i.ready;
  assign room       = len_q < LEN_W'(MAX_LEN);
  assign we_a       = in_acc && room;

  // count buffer entries plus the read in flight, minus the one leaving now
  assign occupancy  = {1'b0, buf_cnt} + {2'b00, rd_pend_q} - {2'b00, buf_pop};
  assign can_issue  = occupancy < 3'd2;

  // next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_LOAD: begin
        if (in_acc && in_i.is_final) begin
          state_d = dec_q ? ST_SCATTER : ST_GATHER;
        end
      end
      ST_GATHER: begin
        if (can_issue && gen_last) begin
          state_d = ST_LOAD;
        end
      end
      ST_SCATTER: begin
        if (gen_last) begin
          state_d = ST_DRAIN;
        end
      end
      ST_DRAIN: begin
        if (can_issue && !wr_pend_q && ((LEN_W'(k_q) + LEN_W'(1)) == len_q)) begin
          state_d = ST_LOAD;
        end
      end
      default: state_d = ST_LOAD;
    endcase
  end

  // outputs of the sequencer
  always_comb begin
    gen_ctrl   = '0;
    issue      = 1'b0;
    issue_last = 1'b0;
    re_a       = 1'b0;
    raddr_a    = gen_idx;
    re_b       = 1'b0;
    raddr_b    = k_q;
    scat       = 1'b0;
    unique case (state_q)
      ST_LOAD: begin
        gen_ctrl.start = in_acc && in_i.is_final;
      end
      ST_GATHER: begin
        issue            = can_issue;
        issue_last       = gen_last;
        re_a             = can_issue;
        raddr_a          = gen_idx;
        gen_ctrl.advance = can_issue;
      end
      ST_SCATTER: begin
        scat             = 1'b1;
        re_a             = 1'b1;
        raddr_a          = gen_cnt;
        gen_ctrl.advance = 1'b1;
      end
      ST_DRAIN: begin
        // hold reads until the last scatter write has landed
        issue      = can_issue && !wr_pend_q;
        issue_last = (LEN_W'(k_q) + LEN_W'(1)) == len_q;
        re_b       = issue;
        raddr_b    = k_q;
      end
      default: begin
        issue = 1'b0;
      end
    endcase
  end

  assign burst_done = issue && issue_last;

  always_comb begin
    len_d = len_q;
    ovf_d = ovf_q;
    k_d   = k_q;
    if (in_acc) begin
      if (room) begin
        len_d = len_q + LEN_W'(1);
      end else begin
        ovf_d = 1'b1;
      end
    end
    if (state_q == ST_SCATTER) begin
      k_d = '0;
    end else if (state_q == ST_DRAIN && issue) begin
      k_d = k_q + ADDR_W'(1);
    end
    if (burst_done) begin
      len_d = '0;
      ovf_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= ST_LOAD;
      len_q     <= '0;
      ovf_q     <= 1'b0;
      k_q       <= '0;
      rd_pend_q <= 1'b0;
      wr_pend_q <= 1'b0;
    end else begin
      state_q   <= state_d;
      len_q     <= len_d;
      ovf_q     <= ovf_d;
      k_q       <= k_d;
      rd_pend_q <= issue;
      wr_pend_q <= scat;
    end
  end

  always_ff @(posedge clk_i) begin
    rd_from_b_q <= (state_q == ST_DRAIN);
    rd_last_q   <= issue_last;
    rd_ovf_q    <= ovf_q;
    wr_addr_q   <= gen_idx;
  end

  rft_order_gen #(
    .MAX_LEN (MAX_LEN)
  ) u_order_gen (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .ctrl_i  (gen_ctrl),
    .len_i   (len_q),
    .rails_i (rail_q),
    .idx_o   (gen_idx),
    .cnt_o   (gen_cnt),
    .last_o  (gen_last)
  );

  // message RAM: written while loading, read by gather or scatter
  rft_ram #(
    .WIDTH (BYTE_W),
    .DEPTH (MAX_LEN)
  ) u_msg_ram (
    .clk_i   (clk_i),
    .we_i    (we_a),
    .waddr_i (len_q[ADDR_W-1:0]),
    .wdata_i (in_i.data_byte),
    .re_i    (re_a),
    .raddr_i (raddr_a),
    .rdata_o (rdata_a)
  );

  // result RAM: decrypt scatters into it, then reads out in order
  rft_ram #(
    .WIDTH (BYTE_W),
    .DEPTH (MAX_LEN)
  ) u_res_ram (
    .clk_i   (clk_i),
    .we_i    (wr_pend_q),
    .waddr_i (wr_addr_q),
    .wdata_i (rdata_a),
    .re_i    (re_b),
    .raddr_i (raddr_b),
    .rdata_o (rdata_b)
  );

  always_comb begin
    push_item.out_byte  = rd_from_b_q ? rdata_b : rdata_a;
    push_item.out_final = rd_last_q;
    push_item.overflow  = rd_ovf_q;
  end

  rft_out_buf u_out_buf (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .push_i (rd_pend_q),
    .item_i (push_item),
    .cnt_o  (buf_cnt),
    .pop_o  (buf_pop),
    .out_o  (out_o)
  );

  `RFT_ASSERT_NEVER(a_buf_overrun, clk_i, rst_ni, rd_pend_q && buf_cnt == 2'd2 && !buf_pop)
  `RFT_ASSERT_NEVER(a_res_hazard, clk_i, rst_ni, re_b && wr_pend_q && raddr_b == wr_addr_q)
  `RFT_ASSERT(a_len_bound, clk_i, rst_ni, len_q <= LEN_W'(MAX_LEN))
  `RFT_ASSERT(a_burst_end, clk_i, rst_ni, burst_done |=> state_q == ST_LOAD && len_q == '0)

endmodule
